FILE: hw/rtl/kme_pkg.sv
// kme_pkg: shared types, constants and controller states for the mst engine
// no dependencies

package kme_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int MAX_EDGES    = 256;
   localparam int TABLE_SIZE   = 64;
   localparam int VTX_W        = 6;
   localparam int EDGE_AW      = $clog2(MAX_EDGES);
   localparam int CNT_W        = $clog2(MAX_EDGES + 1);
   localparam int VC_W         = 7;
   localparam int COST_W       = 24;
   localparam int WGT_W        = 16;
   localparam logic [VC_W-1:0] VC_RESET = 7'd64;
   localparam int LIMIT_CAP = (MAX_VERTICES < TABLE_SIZE) ? MAX_VERTICES : TABLE_SIZE;
   localparam logic [VC_W-1:0] VC_CAP = VC_W'(LIMIT_CAP);
   localparam logic REG_VERTEX_COUNT = 1'b0;

   typedef struct packed {
      logic [VTX_W-1:0]        end_a;
      logic [VTX_W-1:0]        end_b;
      logic signed [WGT_W-1:0] edge_weight_in;
      logic                    last_edge;
   } req_type;

   typedef struct packed {
      logic [VTX_W-1:0]         tree_a;
      logic [VTX_W-1:0]         tree_b;
      logic signed [WGT_W-1:0]  tree_weight;
      logic                     edge_valid;
      logic signed [COST_W-1:0] total_cost;
      logic                     dropped_flag;
      logic                     last_result;
   } rsp_type;

   typedef struct packed {
      logic [VTX_W-1:0]        a;
      logic [VTX_W-1:0]        b;
      logic signed [WGT_W-1:0] w;
   } edge_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SORT_I, ST_LOAD_I, ST_SORT_J, ST_CMP_J,
      ST_SCAN, ST_LOAD_K, ST_FA_RD, ST_FA_CHK, ST_FB_RD, ST_FB_CHK, ST_FINISH
   } state_type;

   typedef struct packed {
      logic sort_init;
      logic load_i;
      logic cmp_j;
      logic write_i;
      logic scan_init;
      logic load_k;
      logic find_step;
      logic save_ra;
      logic unite;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic i_end;
      logic j_end;
      logic k_end;
      logic root_hit;
   } status_type;

endpackage

FILE: hw/rtl/kme_ctrl.sv
// kme_ctrl: sequencer for sort, scan and root walks
// depends on kme_pkg

module kme_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  kme_pkg::status_type status,
   output kme_pkg::cmd_type    cmd,
   output logic                busy
);
   import kme_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               cmd.sort_init = 1'b1;
               state_in = ST_SORT_I;
            end
         end
         ST_SORT_I: begin
            if (status.i_end) begin
               cmd.scan_init = 1'b1;
               state_in = ST_SCAN;
            end else state_in = ST_LOAD_I;
         end
         ST_LOAD_I: begin
            cmd.load_i = 1'b1;
            state_in = ST_SORT_J;
         end
         ST_SORT_J: begin
            if (status.j_end) begin
               cmd.write_i = 1'b1;
               state_in = ST_SORT_I;
            end else state_in = ST_CMP_J;
         end
         ST_CMP_J: begin
            cmd.cmp_j = 1'b1;
            state_in = ST_SORT_J;
         end
         ST_SCAN: begin
            if (status.k_end) state_in = ST_FINISH;
            else              state_in = ST_LOAD_K;
         end
         ST_LOAD_K: begin
            cmd.load_k = 1'b1;
            state_in = ST_FA_RD;
         end
         ST_FA_RD: state_in = ST_FA_CHK;
         ST_FA_CHK: begin
            if (status.root_hit) begin
               cmd.save_ra = 1'b1;
               state_in = ST_FB_RD;
            end else begin
               cmd.find_step = 1'b1;
               state_in = ST_FA_RD;
            end
         end
         ST_FB_RD: state_in = ST_FB_CHK;
         ST_FB_CHK: begin
            if (status.root_hit) begin
               cmd.unite = 1'b1;
               state_in = ST_SCAN;
            end else begin
               cmd.find_step = 1'b1;
               state_in = ST_FB_RD;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: hw/rtl/kme_datapath.sv
// kme_datapath: edge store, exchange sort datapath, union-find table, result
// depends on kme_pkg

module kme_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  kme_pkg::req_type      req,
   input  logic [kme_pkg::VC_W-1:0] vertex_count,
   input  kme_pkg::cmd_type      cmd,
   output kme_pkg::status_type   status,
   output logic                  rsp_valid,
   output kme_pkg::rsp_type      rsp
);
   import kme_pkg::*;

   edge_type              edge_mem [MAX_EDGES];
   edge_type              mem_rd_ff;
   logic [VTX_W-1:0]      root_mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] root_vld_ff;
   logic [VTX_W-1:0]      root_rd_ff, vq_ff;
   logic                  vld_rd_ff;

   logic [CNT_W-1:0]  total_ff, i_ff, j_ff, k_ff;
   edge_type          cur_ff, scan_ff;
   logic [VTX_W-1:0]  v_ff, ra_ff;
   logic signed [COST_W-1:0] cost_ff;
   logic              drop_ff;
   rsp_type           pend_ff;
   logic              pend_vld_ff;
   logic              out_vld_ff;
   rsp_type           out_ff;

   logic [VC_W-1:0]    lim;
   logic               bad;
   logic [EDGE_AW-1:0] rd_addr, wr_addr;
   logic               rd_en;
   logic               wr_en;
   edge_type           wr_data;
   logic [VTX_W-1:0]   p;
   logic               swap;
   logic signed [COST_W-1:0] cost_new;
   rsp_type            fin_rsp;

   assign lim = (vertex_count > VC_CAP) ? VC_CAP : vertex_count;
   assign bad = ({1'b0, req.end_a} >= lim) || ({1'b0, req.end_b} >= lim) ||
                (total_ff >= CNT_W'(MAX_EDGES));

   // read address follows the sequencer phase
   always_comb begin
      if (cmd.scan_init || cmd.sort_init) rd_addr = '0;
      else if (cmd.load_i)                rd_addr = EDGE_AW'(i_ff + 1'b1);
      else if (cmd.write_i)               rd_addr = EDGE_AW'(i_ff + 1'b1);
      else if (cmd.cmp_j)                 rd_addr = EDGE_AW'(j_ff + 1'b1);
      else if (cmd.unite)                 rd_addr = EDGE_AW'(k_ff + 1'b1);
      else                                rd_addr = EDGE_AW'(k_ff);
   end

   assign rd_en = cmd.sort_init | cmd.scan_init | cmd.load_i | cmd.write_i |
                  cmd.cmp_j | cmd.unite;

   assign swap = (cur_ff.w >= mem_rd_ff.w);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = EDGE_AW'(total_ff);
      wr_data = '{a: req.end_a, b: req.end_b, w: req.edge_weight_in};
      if (load && !bad) wr_en = 1'b1;
      if (cmd.cmp_j && swap) begin
         wr_en = 1'b1; wr_addr = EDGE_AW'(j_ff); wr_data = cur_ff;
      end
      if (cmd.write_i) begin
         wr_en = 1'b1; wr_addr = EDGE_AW'(i_ff); wr_data = cur_ff;
      end
   end

   // read register holds between read commands; a same-address write is forwarded
   always_ff @(posedge clock) begin
      if (wr_en) edge_mem[wr_addr] <= wr_data;
      if (rd_en) mem_rd_ff <= (wr_en && (wr_addr == rd_addr)) ? wr_data : edge_mem[rd_addr];
   end

   assign p = vld_rd_ff ? root_rd_ff : vq_ff;

   always_ff @(posedge clock) begin
      if (cmd.unite && (ra_ff != p)) root_mem[ra_ff] <= p;
      root_rd_ff <= root_mem[v_ff];
   end

   always_ff @(posedge clock) begin
      vld_rd_ff <= root_vld_ff[v_ff];
      vq_ff     <= v_ff;
   end

   assign cost_new = cost_ff + COST_W'(scan_ff.w);

   // final transaction: pending edge or empty tree, with drop and last marks
   always_comb begin
      if (pend_vld_ff) fin_rsp = pend_ff;
      else             fin_rsp = '0;
      fin_rsp.dropped_flag = drop_ff;
      fin_rsp.last_result  = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_vld_ff <= '0;
         total_ff    <= '0;
         cost_ff     <= '0;
         drop_ff     <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         out_vld_ff <= cmd.finish || (cmd.unite && (ra_ff != p) && pend_vld_ff);
         if (load) begin
            if (bad) drop_ff  <= 1'b1;
            else     total_ff <= total_ff + 1'b1;
         end
         if (cmd.unite && (ra_ff != p)) begin
            root_vld_ff[ra_ff] <= 1'b1;
            cost_ff     <= cost_new;
            pend_vld_ff <= 1'b1;
         end
         if (cmd.finish) begin
            root_vld_ff <= '0;
            total_ff    <= '0;
            cost_ff     <= '0;
            drop_ff     <= 1'b0;
            pend_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sort_init) i_ff <= '0;
      if (cmd.write_i)   i_ff <= i_ff + 1'b1;
      if (cmd.load_i) begin
         cur_ff <= mem_rd_ff;
         j_ff   <= i_ff + 1'b1;
      end
      if (cmd.cmp_j) begin
         if (swap) cur_ff <= mem_rd_ff;
         j_ff <= j_ff + 1'b1;
      end
      if (cmd.scan_init) k_ff <= '0;
      if (cmd.load_k) begin
         scan_ff <= mem_rd_ff;
         v_ff    <= mem_rd_ff.a;
      end
      if (cmd.find_step) v_ff <= p;
      if (cmd.save_ra) begin
         ra_ff <= p;
         v_ff  <= scan_ff.b;
      end
      if (cmd.unite) begin
         k_ff <= k_ff + 1'b1;
         if (ra_ff != p) begin
            out_ff  <= pend_ff;
            pend_ff <= '{tree_a: scan_ff.a, tree_b: scan_ff.b, tree_weight: scan_ff.w,
                         edge_valid: 1'b1, total_cost: cost_new,
                         dropped_flag: 1'b0, last_result: 1'b0};
         end
      end
      if (cmd.finish) out_ff <= fin_rsp;
   end

   assign status.i_end    = (i_ff >= total_ff);
   assign status.j_end    = (j_ff >= total_ff);
   assign status.k_end    = (k_ff >= total_ff);
   assign status.root_hit = (p == v_ff);

   assign rsp_valid = out_vld_ff;
   assign rsp       = out_ff;

endmodule

FILE: hw/rtl/kruskal_mst_engine.sv
// kruskal_mst_engine: top level, csr port, controller and datapath
// depends on kme_pkg, kme_ctrl, kme_datapath
//
//  channel   ports                         handshake
//  request   req_start, req_busy, req      accepted when req_start && !req_busy
//  response  rsp_valid, rsp                one-cycle strobe, cannot be stalled
//  config    psel..pready, paddr, pwdata   apb write, pready tied high
//
// an edge with last_edge 0 is stored in its accept cycle unless it is dropped, busy stays low
// the last edge starts the run: an exchange sort of the stored edges
//   (one edge-memory port pair, one compare at a time), then for each edge
//   a root walk from both ends through the union-find table
// results come one per selected edge (one empty result if none), one edge late,
//   the final one the cycle after the finish state, when busy has dropped again
// reset is synchronous: vertex_count 64, empty store, identity root table
// the receiver cannot stall, results are never held

module kruskal_mst_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_start,
   output logic                 req_busy,
   input  kme_pkg::req_type     req,
   output logic                 rsp_valid,
   output kme_pkg::rsp_type     rsp,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import kme_pkg::*;

   logic [VC_W-1:0] vc_ff;
   logic            accept;
   cmd_type         cmd;
   status_type      status;

   // vertex count register, written in the apb access phase
   always_ff @(posedge clock) begin
      if (reset) vc_ff <= VC_RESET;
      else if (psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT))
         vc_ff <= pwdata[VC_W-1:0];
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {{(32-VC_W){1'b0}}, vc_ff} : '0;

   // a transaction is taken whenever the sequencer is idle
   assign accept = req_start && !req_busy;

   kme_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .go     (accept && req.last_edge),
      .status (status),
      .cmd    (cmd),
      .busy   (req_busy)
   );

   kme_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .req          (req),
      .vertex_count (vc_ff),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp          (rsp)
   );

endmodule

FILE: hw/rtl/kme_checker.sv
// kme_checker: port-level assertions for the mst engine, bound to the top
// depends on kme_pkg

module kme_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_start,
   input logic             req_busy,
   input kme_pkg::req_type req,
   input logic             rsp_valid,
   input kme_pkg::rsp_type rsp
);
   import kme_pkg::*;

   a_rsp_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_busy))
      else $error("result outside a run");

   a_mid_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.last_result |-> rsp.edge_valid && !rsp.dropped_flag && req_busy)
      else $error("bad intermediate result");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.edge_valid |-> rsp.last_result && (rsp.total_cost == '0))
      else $error("bad empty-tree result");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      req_start && !req_busy && !req.last_edge |=> !req_busy)
      else $error("busy after a plain load");

endmodule

bind kruskal_mst_engine kme_checker u_kme_checker (
   .clock     (clock),
   .reset     (reset),
   .req_start (req_start),
   .req_busy  (req_busy),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);
